// File: rtl/slm_pkg.sv
package slm_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int DATA_W     = 32;

    localparam logic [1:0] KIND_PUSH_A = 2'd0;
    localparam logic [1:0] KIND_PUSH_B = 2'd1;
    localparam logic [1:0] KIND_MERGE  = 2'd2;

    typedef struct packed {
        logic push_a;
        logic push_b;
        logic emit;
        logic finish;
    } slm_cmd_t;

    typedef struct packed {
        logic load_ok;
        logic last_pick;
    } slm_status_t;

endpackage

// File: rtl/sorted_list_merge_unit.sv
// Pushes: one per cycle while no merge runs, no result; a push to a full list is dropped.
// Merge: the merge transfer sets the state register, then the first result goes to the
//   output register; then one result per cycle while out_stall is low (one compare of
//   both list heads per cycle), count_a + count_b results in all, or one if both are empty.
// Input is stalled for the whole merge run; next item is taken the cycle after.
// Reset (async, active low) clears counts, the dropped-push flag and the output valid.
module sorted_list_merge_unit
    import slm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               kind,
    input  logic signed [DATA_W-1:0] element,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] merged_value,
    output logic                     last,
    output logic                     empty_res,
    output logic                     overflow
);

    slm_cmd_t    cmd;
    slm_status_t status;

    slm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    slm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .element      (element),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .merged_value (merged_value),
        .last         (last),
        .empty_res    (empty_res),
        .overflow     (overflow)
    );

endmodule

// File: rtl/slm_ctrl.sv
module slm_ctrl
    import slm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  kind,
    output logic        in_stall,
    input  slm_status_t status,
    output slm_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take_in;

    assign in_stall = (state_reg != ST_IDLE);
    assign take_in  = (state_reg == ST_IDLE) && in_valid;

    always_comb
    begin
        cmd.push_a = take_in && (kind == KIND_PUSH_A);
        cmd.push_b = take_in && (kind == KIND_PUSH_B);
        cmd.emit   = (state_reg == ST_MERGE) && status.load_ok;
        cmd.finish = cmd.emit && status.last_pick;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_in && (kind == KIND_MERGE))
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (cmd.finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/slm_datapath.sv
module slm_datapath
    import slm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  slm_cmd_t                 cmd,
    output slm_status_t              status,
    input  logic signed [DATA_W-1:0] element,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] merged_value,
    output logic                     last,
    output logic                     empty_res,
    output logic                     overflow
);

    logic signed [DATA_W-1:0] store_a [LIST_DEPTH];
    logic signed [DATA_W-1:0] store_b [LIST_DEPTH];

    logic [CNT_W-1:0] count_a_reg;
    logic [CNT_W-1:0] count_b_reg;
    logic [CNT_W-1:0] ia_reg;
    logic [CNT_W-1:0] ib_reg;
    logic             dropped_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] merged_value_reg;
    logic                     last_reg;
    logic                     empty_reg;
    logic                     overflow_reg;

    logic                     full_a;
    logic                     full_b;
    logic                     a_left;
    logic                     b_left;
    logic                     lists_empty;
    logic                     take_a;
    logic                     pick_last;
    logic [CNT_W-1:0]         ia_inc;
    logic [CNT_W-1:0]         ib_inc;
    logic signed [DATA_W-1:0] head_a;
    logic signed [DATA_W-1:0] head_b;

    assign full_a = (count_a_reg >= CNT_W'(LIST_DEPTH));
    assign full_b = (count_b_reg >= CNT_W'(LIST_DEPTH));

    assign a_left      = (ia_reg < count_a_reg);
    assign b_left      = (ib_reg < count_b_reg);
    assign lists_empty = !a_left && !b_left;
    assign head_a      = store_a[ia_reg[IDX_W-1:0]];
    assign head_b      = store_b[ib_reg[IDX_W-1:0]];
    assign ia_inc      = ia_reg + 1'b1;
    assign ib_inc      = ib_reg + 1'b1;

    // tie goes to list A
    assign take_a    = a_left && (!b_left || (head_a <= head_b));
    assign pick_last = take_a ? ((ia_inc == count_a_reg) && !b_left)
                              : ((ib_inc == count_b_reg) && !a_left);

    assign status.load_ok   = !out_valid_reg || !out_stall;
    assign status.last_pick = lists_empty || pick_last;

    always_ff @(posedge clk)
    begin
        if (cmd.push_a && !full_a)
        begin
            store_a[count_a_reg[IDX_W-1:0]] <= element;
        end
        if (cmd.push_b && !full_b)
        begin
            store_b[count_b_reg[IDX_W-1:0]] <= element;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg <= '0;
            count_b_reg <= '0;
            ia_reg      <= '0;
            ib_reg      <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push_a)
            begin
                if (full_a)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    count_a_reg <= count_a_reg + 1'b1;
                end
            end
            if (cmd.push_b)
            begin
                if (full_b)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    count_b_reg <= count_b_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                count_a_reg <= '0;
                count_b_reg <= '0;
                ia_reg      <= '0;
                ib_reg      <= '0;
                dropped_reg <= 1'b0;
            end
            else if (cmd.emit && !lists_empty)
            begin
                if (take_a)
                begin
                    ia_reg <= ia_inc;
                end
                else
                begin
                    ib_reg <= ib_inc;
                end
            end
        end
    end

    // output register: hold while stalled, reload on each emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            merged_value_reg <= lists_empty ? '0 : (take_a ? head_a : head_b);
            last_reg         <= status.last_pick;
            empty_reg        <= lists_empty;
            overflow_reg     <= dropped_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign merged_value = merged_value_reg;
    assign last         = last_reg;
    assign empty_res    = empty_reg;
    assign overflow     = overflow_reg;

endmodule

// File: tb/sv/sorted_list_merge_unit_tb.sv
`timescale 1ns / 1ps

module sorted_list_merge_unit_tb;
    import slm_pkg::*;

    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam int         DIRECTED_ITEMS = 23;
    localparam int         RANDOM_ITEMS   = 320;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         QUIET_LIMIT    = 2000;

    typedef struct {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] element;
    } list_cmd_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     empty;
        logic                     ovf;
    } merge_result_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_stall;
    logic [1:0]               kind         = KIND_PUSH_A;
    logic signed [DATA_W-1:0] element      = '0;
    logic                     out_valid;
    logic                     out_stall    = 1'b0;
    logic signed [DATA_W-1:0] merged_value;
    logic                     last;
    logic                     empty_res;
    logic                     overflow;

    // pending stimulus, predicted merge output, and the predictor's view of the lists
    list_cmd_t                pending_cmds[$];
    merge_result_t            merge_expect[$];
    logic signed [DATA_W-1:0] list_a[$];
    logic signed [DATA_W-1:0] list_b[$];
    bit                       dropped      = 1'b0;

    int  total_cmds     = 0;
    int  cmds_taken     = 0;
    int  mismatches     = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    int  quiet_cycles   = 0;
    bit  send_idle_on   = 1'b1;
    bit  recv_idle_on   = 1'b1;

    wire in_xfer  = in_valid && !in_stall;
    wire out_xfer = out_valid && !out_stall;

    sorted_list_merge_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .element      (element),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .merged_value (merged_value),
        .last         (last),
        .empty_res    (empty_res),
        .overflow     (overflow)
    );

    always #5 clk = ~clk;

    function automatic int draw_wait(input bit idle_on);
        return idle_on ? $urandom_range(0, 9) : 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("ERROR at %0t: %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic queue_cmd(input logic [1:0] k, input logic signed [DATA_W-1:0] e);
        list_cmd_t c;
        c.kind    = k;
        c.element = e;
        pending_cmds.push_back(c);
    endtask

    task automatic predict_merge_output(input logic [1:0] k,
                                        input logic signed [DATA_W-1:0] e);
        int            ia;
        int            ib;
        int            total;
        bit            take_a;
        merge_result_t r;
        case (k)
            KIND_PUSH_A:
            begin
                if (list_a.size() >= LIST_DEPTH)
                    dropped = 1'b1;
                else
                    list_a.push_back(e);
            end
            KIND_PUSH_B:
            begin
                if (list_b.size() >= LIST_DEPTH)
                    dropped = 1'b1;
                else
                    list_b.push_back(e);
            end
            KIND_MERGE:
            begin
                total = list_a.size() + list_b.size();
                if (total == 0)
                begin
                    r.value = '0;
                    r.last  = 1'b1;
                    r.empty = 1'b1;
                    r.ovf   = dropped;
                    merge_expect.push_back(r);
                end
                else
                begin
                    ia = 0;
                    ib = 0;
                    for (int n = 0; n < total; n++)
                    begin
                        // take the head of A on a tie
                        if (ia < list_a.size() && ib < list_b.size())
                            take_a = (list_a[ia] <= list_b[ib]);
                        else
                            take_a = (ia < list_a.size());
                        if (take_a)
                        begin
                            r.value = list_a[ia];
                            ia++;
                        end
                        else
                        begin
                            r.value = list_b[ib];
                            ib++;
                        end
                        r.last  = (n == total - 1);
                        r.empty = 1'b0;
                        r.ovf   = dropped;
                        merge_expect.push_back(r);
                    end
                end
                list_a.delete();
                list_b.delete();
                dropped = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // one load-then-merge run: mostly ascending lists, some ties, some unsorted, some overflow
    task automatic queue_random_run();
        int                       na;
        int                       nb;
        int                       size_pick;
        int                       style;
        logic signed [DATA_W-1:0] qa[$];
        logic signed [DATA_W-1:0] qb[$];
        logic signed [DATA_W-1:0] v;
        bit                       pick_a;
        size_pick = $urandom_range(0, 19);
        if (size_pick < 14)
        begin
            na = $urandom_range(0, 6);
            nb = $urandom_range(0, 6);
        end
        else if (size_pick < 18)
        begin
            na = $urandom_range(0, LIST_DEPTH);
            nb = $urandom_range(0, LIST_DEPTH);
        end
        else
        begin
            na = $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 4);
            nb = $urandom_range(0, LIST_DEPTH + 4);
        end
        style = $urandom_range(0, 9);
        for (int i = 0; i < na + nb; i++)
        begin
            if (style >= 6 && style < 8)
                v = $signed($urandom_range(0, 6)) - 3;
            else
                v = $urandom;
            if (i < na)
                qa.push_back(v);
            else
                qb.push_back(v);
        end
        if (style < 8)
        begin
            qa.sort();
            qb.sort();
        end
        while (qa.size() > 0 || qb.size() > 0)
        begin
            if (qa.size() > 0 && qb.size() > 0)
                pick_a = ($urandom_range(0, 1) == 1);
            else
                pick_a = (qa.size() > 0);
            if (pick_a)
                queue_cmd(KIND_PUSH_A, qa.pop_front());
            else
                queue_cmd(KIND_PUSH_B, qb.pop_front());
            if ($urandom_range(0, 15) == 0)
                queue_cmd(KIND_UNUSED, $urandom);
        end
        queue_cmd(KIND_MERGE, $urandom);
    endtask

    // sender: feed the block from the pending queue with random gaps
    always @(posedge clk)
    begin : drive_proc
        bit        load;
        list_cmd_t c;
        if (rst_n)
        begin
            load = 1'b0;
            if (in_xfer)
            begin
                predict_merge_output(kind, element);
                cmds_taken++;
                if ($urandom_range(0, 29) == 0)
                    send_idle_on = !send_idle_on;
                send_gap = draw_wait(send_idle_on);
                if (send_gap == 0 && pending_cmds.size() > 0)
                    load = 1'b1;
            end
            else if (!in_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_cmds.size() > 0)
                    load = 1'b1;
            end
            if (load)
            begin
                c = pending_cmds.pop_front();
                kind     <= c.kind;
                element  <= c.element;
                in_valid <= 1'b1;
            end
            else if (in_xfer)
                in_valid <= 1'b0;
        end
    end

    // receiver: hold off for a random number of cycles after each transfer
    always @(posedge clk)
    begin : stall_proc
        int n;
        if (rst_n)
        begin
            if (out_xfer)
            begin
                if ($urandom_range(0, 29) == 0)
                    recv_idle_on = !recv_idle_on;
                n = draw_wait(recv_idle_on);
                stall_left <= n;
                out_stall  <= (n != 0);
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= (stall_left > 1);
            end
        end
    end

    always @(posedge clk)
    begin : check_proc
        merge_result_t r;
        if (rst_n && out_xfer)
        begin
            if (merge_expect.size() == 0)
                report_mismatch("result with nothing expected", merged_value, '0);
            else
            begin
                r = merge_expect.pop_front();
                if (merged_value !== r.value)
                    report_mismatch("merged_value", merged_value, r.value);
                if (last !== r.last)
                    report_mismatch("last", DATA_W'(last), DATA_W'(r.last));
                if (empty_res !== r.empty)
                    report_mismatch("empty_res", DATA_W'(empty_res), DATA_W'(r.empty));
                if (overflow !== r.ovf)
                    report_mismatch("overflow", DATA_W'(overflow), DATA_W'(r.ovf));
            end
        end
    end

    // end the run if no transfer happens on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_xfer || out_xfer)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        // both lists empty
        queue_cmd(KIND_MERGE, 32'sh7FFFFFFF);
        // extremes on both lists
        queue_cmd(KIND_PUSH_A, 32'sh80000000);
        queue_cmd(KIND_PUSH_B, 32'shFFFFFFFF);
        queue_cmd(KIND_PUSH_B, 32'sh00000000);
        queue_cmd(KIND_PUSH_A, 32'sh7FFFFFFF);
        queue_cmd(KIND_MERGE, 32'sh80000000);
        // ties between the lists
        queue_cmd(KIND_PUSH_A, 32'sd5);
        queue_cmd(KIND_PUSH_B, 32'sd5);
        queue_cmd(KIND_PUSH_A, 32'sd5);
        queue_cmd(KIND_PUSH_B, 32'sd6);
        queue_cmd(KIND_MERGE, 32'sh0);
        // unsorted input
        queue_cmd(KIND_PUSH_A, 32'sd10);
        queue_cmd(KIND_PUSH_A, 32'sd3);
        queue_cmd(KIND_PUSH_B, 32'sd7);
        queue_cmd(KIND_PUSH_B, -32'sd2);
        queue_cmd(KIND_MERGE, 32'sh0);
        // unused kind is ignored, so this merge sees empty lists
        queue_cmd(KIND_UNUSED, 32'shAAAA5555);
        queue_cmd(KIND_MERGE, 32'sh0);
        // only one list filled
        queue_cmd(KIND_PUSH_B, -32'sd100);
        queue_cmd(KIND_PUSH_B, 32'sd100);
        queue_cmd(KIND_MERGE, 32'shFFFFFFFF);
        queue_cmd(KIND_PUSH_A, 32'sh5555AAAA);
        queue_cmd(KIND_MERGE, 32'sh0);
        while (pending_cmds.size() < DIRECTED_ITEMS + RANDOM_ITEMS)
            queue_random_run();
        total_cmds = pending_cmds.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (cmds_taken < total_cmds)
            @(posedge clk);
        while (merge_expect.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (merge_expect.size() != 0)
            report_mismatch("results never arrived", merge_expect.size(), '0);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
